### rtl/vpid_pkg.sv
// Shared widths, register map and types for the velocity-form PID controller.
// No dependencies; imported by every module of the block.
package vpid_pkg;

    localparam int SIG_W   = 16;              // measured / target, signed Q8.8
    localparam int ERR_W   = SIG_W + 1;       // exact error width
    localparam int GAIN_W  = 16;              // gains, signed Q8.8
    localparam int TS_W    = 16;              // sample time, unsigned Q0.16
    localparam int LIM_W   = 32;              // limits and drive, signed Q16.16
    localparam int COEF_W  = 40;              // precomputed coefficients
    localparam int ACC_W   = 48;              // saturating drive accumulator
    localparam int PROD_W  = COEF_W + ERR_W;  // one coefficient times one error
    localparam int SUM_W   = PROD_W + 3;      // three products plus the accumulator
    localparam int DIV_N_W = GAIN_W + TS_W;   // |kd| * 2^16
    localparam int DIV_D_W = TS_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SAMPLE_TIME = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUT_MIN     = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_MAX     = 3'd5;

    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd256;
    localparam logic [TS_W-1:0]   SAMPLE_TIME_RST = 16'd6554;
    localparam logic [LIM_W-1:0]  OUT_MIN_RST     = 32'h8000_0000;
    localparam logic [LIM_W-1:0]  OUT_MAX_RST     = 32'h7FFF_FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/vpid_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on vpid_pkg for widths and the status struct.
module vpid_div
    import vpid_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [DIV_N_W-1:0] quotient,
    output div_stat_t          stat
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;

    logic [DIV_D_W:0]   rem_shift;
    logic [DIV_D_W+1:0] diff;

    assign rem_shift = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= CNT_W'(DIV_N_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top while quotient bits shift in below
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DIV_D_W+1]) begin
                rem_reg <= diff[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/velocity_pid_with_clamp.sv
// An accepted s_ word moves through the input, product, accumulate and clamp registers to
// its m_ word; a clear word yields none. Throughput: one word per cycle when not stalled.
// A write to a gain or the sample time recomputes the coefficients through a
// 32-step serial divider: s_tready stays low after that write until the divider is done.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes the history and
// loads every configuration register and coefficient with its reset value.
module velocity_pid_with_clamp
    import vpid_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [15:0] measured, [31:16] target
    input  logic              s_tuser,   // [0] kind (1 = clear history)
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] drive
    output logic              m_tuser,   // [0] limited
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ---------------- configuration registers ----------------
    logic        [GAIN_W-1:0] prop_gain_reg;
    logic        [GAIN_W-1:0] integ_gain_reg;
    logic        [GAIN_W-1:0] deriv_gain_reg;
    logic        [TS_W-1:0]   sample_time_reg;
    logic        [LIM_W-1:0]  out_min_reg;
    logic        [LIM_W-1:0]  out_max_reg;
    logic                     restart_reg;

    logic                     cfg_wr;
    logic        [IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            sample_time_reg <= SAMPLE_TIME_RST;
            out_min_reg     <= OUT_MIN_RST;
            out_max_reg     <= OUT_MAX_RST;
            restart_reg     <= 1'b0;
        end else begin
            restart_reg <= 1'b0;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_PROP_GAIN: begin
                        prop_gain_reg <= pwdata[GAIN_W-1:0];
                        restart_reg   <= 1'b1;
                    end
                    REG_INTEG_GAIN: begin
                        integ_gain_reg <= pwdata[GAIN_W-1:0];
                        restart_reg    <= 1'b1;
                    end
                    REG_DERIV_GAIN: begin
                        deriv_gain_reg <= pwdata[GAIN_W-1:0];
                        restart_reg    <= 1'b1;
                    end
                    REG_SAMPLE_TIME: begin
                        sample_time_reg <= pwdata[TS_W-1:0];
                        restart_reg     <= 1'b1;
                    end
                    REG_OUT_MIN: out_min_reg <= pwdata[LIM_W-1:0];
                    REG_OUT_MAX: out_max_reg <= pwdata[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PROP_GAIN:   prdata = DATA_W'(prop_gain_reg);
            REG_INTEG_GAIN:  prdata = DATA_W'(integ_gain_reg);
            REG_DERIV_GAIN:  prdata = DATA_W'(deriv_gain_reg);
            REG_SAMPLE_TIME: prdata = DATA_W'(sample_time_reg);
            REG_OUT_MIN:     prdata = DATA_W'(out_min_reg);
            REG_OUT_MAX:     prdata = DATA_W'(out_max_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- coefficient precompute ----------------
    logic        [GAIN_W-1:0]  kd_mag;
    logic        [DIV_D_W-1:0] ts_div;
    logic        [DIV_N_W-1:0] dt_quo;
    div_stat_t                 div_stat;
    logic                      coef_busy;

    logic signed [COEF_W-1:0]  kp_x;
    logic signed [COEF_W-1:0]  ki_ts;
    logic signed [COEF_W-1:0]  it_next;
    logic signed [COEF_W-1:0]  dt_next;
    logic signed [COEF_W-1:0]  coef_now_reg;
    logic signed [COEF_W-1:0]  coef_last_reg;
    logic signed [COEF_W-1:0]  coef_older_reg;

    assign kd_mag = deriv_gain_reg[GAIN_W-1] ? (~deriv_gain_reg + GAIN_W'(1))
                                             : deriv_gain_reg;
    // a zero sample time divides as one
    assign ts_div = (sample_time_reg == '0) ? DIV_D_W'(1) : sample_time_reg;

    vpid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (restart_reg),
        .dividend ({kd_mag, {TS_W{1'b0}}}),
        .divisor  (ts_div),
        .quotient (dt_quo),
        .stat     (div_stat)
    );

    assign coef_busy = restart_reg || div_stat.busy;

    assign kp_x  = COEF_W'($signed(prop_gain_reg));
    assign ki_ts = COEF_W'($signed(integ_gain_reg) * $signed({1'b0, sample_time_reg}));
    // round to nearest, ties toward plus infinity
    assign it_next = (ki_ts + COEF_W'(32768)) >>> TS_W;
    assign dt_next = deriv_gain_reg[GAIN_W-1] ? -COEF_W'(dt_quo) : COEF_W'(dt_quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_now_reg   <= COEF_W'($signed(PROP_GAIN_RST));
            coef_last_reg  <= -COEF_W'($signed(PROP_GAIN_RST));
            coef_older_reg <= '0;
        end else if (div_stat.done) begin
            coef_now_reg   <= kp_x + it_next + dt_next;
            coef_last_reg  <= -kp_x - (dt_next <<< 1);
            coef_older_reg <= dt_next;
        end
    end

    // ---------------- sample pipeline ----------------
    localparam logic signed [SUM_W-1:0] ACC_MAX_X =
        (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ACC_MIN_X = ~ACC_MAX_X;

    logic                     advance;
    logic                     s_accept;

    logic                     in_valid_reg;
    logic                     in_clear_reg;
    logic signed [ERR_W-1:0]  in_err_reg;
    logic signed [ERR_W-1:0]  err_next;

    logic signed [ERR_W-1:0]  err1_reg;
    logic signed [ERR_W-1:0]  err2_reg;

    logic                     pr_valid_reg;
    logic                     pr_clear_reg;
    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] p0_next;
    logic signed [PROD_W-1:0] p1_next;
    logic signed [PROD_W-1:0] p2_next;

    logic                     ac_valid_reg;
    logic signed [ACC_W-1:0]  drive_prev_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [ACC_W-1:0]  acc_next;

    logic                     out_valid_reg;
    logic        [LIM_W-1:0]  out_drive_reg;
    logic                     out_limited_reg;
    logic signed [ACC_W-1:0]  lo_x;
    logic signed [ACC_W-1:0]  hi_x;
    logic signed [ACC_W-1:0]  raised;
    logic signed [ACC_W-1:0]  clamped;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance && !coef_busy;
    assign s_accept = s_tvalid && s_tready;

    assign err_next = ERR_W'($signed(s_tdata[2*SIG_W-1:SIG_W]))
                    - ERR_W'($signed(s_tdata[SIG_W-1:0]));

    assign p0_next = PROD_W'(coef_now_reg)   * PROD_W'(in_err_reg);
    assign p1_next = PROD_W'(coef_last_reg)  * PROD_W'(err1_reg);
    assign p2_next = PROD_W'(coef_older_reg) * PROD_W'(err2_reg);

    assign sum_next = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg)
                    + SUM_W'(drive_prev_reg);

    always_comb begin
        if (sum_next > ACC_MAX_X) begin
            acc_next = ACC_MAX_X[ACC_W-1:0];
        end else if (sum_next < ACC_MIN_X) begin
            acc_next = ACC_MIN_X[ACC_W-1:0];
        end else begin
            acc_next = sum_next[ACC_W-1:0];
        end
    end

    // raise to the lower limit first, then lower to the upper one
    assign lo_x    = ACC_W'($signed(out_min_reg));
    assign hi_x    = ACC_W'($signed(out_max_reg));
    assign raised  = (drive_prev_reg < lo_x) ? lo_x : drive_prev_reg;
    assign clamped = (raised > hi_x) ? hi_x : raised;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            pr_valid_reg   <= 1'b0;
            ac_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            err1_reg       <= '0;
            err2_reg       <= '0;
            drive_prev_reg <= '0;
        end else if (advance) begin
            in_valid_reg  <= s_accept;
            pr_valid_reg  <= in_valid_reg;
            ac_valid_reg  <= pr_valid_reg && !pr_clear_reg;
            out_valid_reg <= ac_valid_reg;
            if (in_valid_reg) begin
                if (in_clear_reg) begin
                    err1_reg <= '0;
                    err2_reg <= '0;
                end else begin
                    err1_reg <= in_err_reg;
                    err2_reg <= err1_reg;
                end
            end
            if (pr_valid_reg) begin
                drive_prev_reg <= pr_clear_reg ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_clear_reg    <= (s_tuser == KIND_CLEAR);
            in_err_reg      <= err_next;
            pr_clear_reg    <= in_clear_reg;
            p0_reg          <= p0_next;
            p1_reg          <= p1_next;
            p2_reg          <= p2_next;
            out_drive_reg   <= clamped[LIM_W-1:0];
            out_limited_reg <= (clamped != drive_prev_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_drive_reg;
    assign m_tuser  = out_limited_reg;

endmodule

### rtl/vpid_chk.sv
// Port-level assertions for velocity_pid_with_clamp, bound to the top level.
// Depends on vpid_pkg for the register map.
module vpid_chk
    import vpid_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [31:0]       m_tdata,
    input logic              m_tuser,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic              pready
);

    logic gain_wr;

    assign gain_wr = psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1:2] == REG_PROP_GAIN  ||
                      paddr[ADDR_W-1:2] == REG_INTEG_GAIN ||
                      paddr[ADDR_W-1:2] == REG_DERIV_GAIN ||
                      paddr[ADDR_W-1:2] == REG_SAMPLE_TIME);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // coefficients are stale right after a gain or sample time write
    a_coef_block: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_wr |=> !s_tready)
        else $error("input accepted while coefficients recompute");

endmodule

bind velocity_pid_with_clamp vpid_chk u_vpid_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pready   (pready)
);

### verif/velocity_pid_with_clamp_test.sv
// Self-checking testbench for velocity_pid_with_clamp: drives sample and clear words,
// programs the gains, sample time and limits over APB and checks each drive word against its own
// fixed-point prediction. Depends on vpid_pkg and the RTL of the block.
module velocity_pid_with_clamp_test
    import vpid_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_SAMPLE = ~KIND_CLEAR;
    localparam logic [IDX_W-1:0] REG_HOLE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_HOLE_B = 3'd7;
    localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int PIPE_DEPTH  = 4;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [LIM_W-1:0] drive;
        logic             limited;
    } drive_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [15:0] measured, [31:16] target
    logic              s_tuser;   // [0] kind
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // [31:0] drive
    logic              m_tuser;   // [0] limited
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // controller image: tuning, coefficients and history
    longint gain_p, gain_i, gain_d, period, lim_lo, lim_hi;
    longint coef_e0, coef_e1, coef_e2;
    longint drive_acc, err_last, err_older;

    drive_t pending_drive[$];
    bit     bursty;
    int     n_errors, n_samples, n_clears, n_checked, n_clamped, n_writes;
    int     idle_cycles = 0;

    velocity_pid_with_clamp u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void refresh_coefs();
        longint ts_div, it_term, dt_term;
        ts_div  = (period == 0) ? 1 : period;
        it_term = (gain_i * period + 32768) >>> 16;
        dt_term = (gain_d * 65536) / ts_div;
        coef_e0 = gain_p + it_term + dt_term;
        coef_e1 = -gain_p - 2 * dt_term;
        coef_e2 = dt_term;
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        case (idx)
            REG_PROP_GAIN:   gain_p = longint'($signed(value[15:0]));
            REG_INTEG_GAIN:  gain_i = longint'($signed(value[15:0]));
            REG_DERIV_GAIN:  gain_d = longint'($signed(value[15:0]));
            REG_SAMPLE_TIME: period = longint'(value[15:0]);
            REG_OUT_MIN:     lim_lo = longint'($signed(value));
            REG_OUT_MAX:     lim_hi = longint'($signed(value));
            default:         return;
        endcase
        refresh_coefs();
    endfunction

    function automatic void predict_sample(input logic [15:0] meas, input logic [15:0] tgt);
        longint err, inc, acc, clamped;
        drive_t want;
        err = longint'($signed(tgt)) - longint'($signed(meas));
        inc = coef_e0 * err + coef_e1 * err_last + coef_e2 * err_older;
        if (inc > 0 && drive_acc > ACC_MAX - inc) begin
            acc = ACC_MAX;
        end else if (inc < 0 && drive_acc < ACC_MIN - inc) begin
            acc = ACC_MIN;
        end else begin
            acc = drive_acc + inc;
        end
        drive_acc = acc;
        err_older = err_last;
        err_last  = err;
        // raise to the floor first, then lower to the ceiling
        clamped = (acc < lim_lo) ? lim_lo : acc;
        clamped = (clamped > lim_hi) ? lim_hi : clamped;
        want.drive   = clamped[31:0];
        want.limited = (clamped != acc);
        if (want.limited) n_clamped++;
        pending_drive.push_back(want);
    endfunction

    function automatic logic [15:0] pick_sig();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic kind, input logic [15:0] meas, input logic [15:0] tgt);
        if (bursty && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tgt, meas};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_CLEAR) begin
            drive_acc = 0;
            err_last  = 0;
            err_older = 0;
            n_clears++;
        end else begin
            predict_sample(meas, tgt);
            n_samples++;
        end
    endtask

    // hold the sender until every drive word is back, then let the pipe empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_reg(idx, value);
        n_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // leave the bus idle between transfers
        @(posedge aclk);
    endtask

    task automatic load_tuning(input shortint kp, input shortint ki, input shortint kd,
                               input logic [15:0] ts, input int lo, input int hi);
        drain_results();
        write_reg(REG_PROP_GAIN, 32'(kp));
        write_reg(REG_INTEG_GAIN, 32'(ki));
        write_reg(REG_DERIV_GAIN, 32'(kd));
        write_reg(REG_SAMPLE_TIME, 32'(ts));
        write_reg(REG_OUT_MIN, 32'(lo));
        write_reg(REG_OUT_MAX, 32'(hi));
    endtask

    // mostly a plant output drifting around a held setpoint, with noise and clears
    task automatic run_batch(input int count);
        logic [15:0] meas, tgt;
        int pick;
        meas = pick_sig();
        tgt  = pick_sig();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                push_word(KIND_CLEAR, 16'($urandom), 16'($urandom));
            end else if (pick <= 3) begin
                push_word(KIND_SAMPLE, pick_sig(), pick_sig());
            end else begin
                if (pick == 4) tgt = pick_sig();
                meas = meas + 16'($urandom_range(0, 512)) - 16'd256;
                push_word(KIND_SAMPLE, meas, tgt);
            end
        end
    endtask

    task automatic test_reset_defaults();
        push_word(KIND_SAMPLE, 16'h8000, 16'h7FFF);
        push_word(KIND_SAMPLE, 16'h7FFF, 16'h8000);
        push_word(KIND_SAMPLE, 16'h0000, 16'h0000);
        push_word(KIND_CLEAR, 16'hFFFF, 16'hFFFF);
        push_word(KIND_SAMPLE, 16'h0100, 16'h0000);
        push_word(KIND_SAMPLE, 16'h0000, 16'h7FFF);
        push_word(KIND_SAMPLE, 16'h7FFF, 16'h7FFF);
        push_word(KIND_CLEAR, 16'h0000, 16'h0000);
        push_word(KIND_CLEAR, 16'h5A5A, 16'hA5A5);
        push_word(KIND_SAMPLE, 16'hFF00, 16'h0080);
    endtask

    task automatic test_saturation_and_limits();
        // huge coefficients drive the accumulator into both rails
        load_tuning(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        repeat (3) push_word(KIND_SAMPLE, 16'h8000, 16'h7FFF);
        repeat (3) push_word(KIND_SAMPLE, 16'h7FFF, 16'h8000);
        // zero sample time and a floor above the ceiling
        load_tuning(256, 128, 64, 16'd0, 1000, -1000);
        push_word(KIND_SAMPLE, 16'h0000, 16'h0400);
        push_word(KIND_SAMPLE, 16'h0400, 16'h0000);
        push_word(KIND_SAMPLE, 16'h1234, 16'hFEDC);
        // writes to unmapped slots must leave the tuning alone
        drain_results();
        write_reg(REG_HOLE_A, $urandom);
        write_reg(REG_HOLE_B, $urandom);
        push_word(KIND_SAMPLE, 16'h0010, 16'h0300);
        push_word(KIND_SAMPLE, 16'hFF00, 16'h0100);
    endtask

    task automatic test_tuning_sweeps();
        load_tuning(shortint'($urandom_range(0, 1024)), shortint'($urandom_range(0, 256)),
                    shortint'($urandom_range(0, 128)), 16'($urandom_range(64, 16384)),
                    -int'($urandom_range(0, 1 << 24)), int'($urandom_range(0, 1 << 24)));
        run_batch(55);
        load_tuning(shortint'($urandom), shortint'($urandom), shortint'($urandom),
                    16'($urandom_range(1, 65535)), int'($urandom), int'($urandom));
        run_batch(25);
        drain_results();
        run_batch(30);
        load_tuning(16'sh8000, 16'sh8000, 16'sh7FFF, 16'hFFFF,
                    32'sh8000_0000, 32'sh7FFF_FFFF);
        run_batch(55);
        load_tuning(shortint'($urandom_range(0, 2048)), shortint'($urandom_range(0, 512)),
                    shortint'($urandom_range(0, 64)), 16'($urandom_range(1, 65535)),
                    -int'($urandom_range(0, 1 << 16)), int'($urandom_range(0, 1 << 16)));
        run_batch(55);
        bursty = 1'b0;
        load_tuning(0, 0, 0, 16'd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        run_batch(55);
        bursty = 1'b1;
        load_tuning(shortint'($urandom), shortint'($urandom), shortint'($urandom),
                    16'($urandom), int'($urandom_range(1, 1 << 20)),
                    -int'($urandom_range(0, 1 << 20)));
        run_batch(55);
    endtask

    task automatic test_steady_tail();
        bursty = 1'b0;
        load_tuning(shortint'($urandom_range(0, 4096)), shortint'($urandom_range(0, 1024)),
                    shortint'($urandom_range(0, 512)), 16'($urandom_range(1, 65535)),
                    -int'($urandom_range(0, 1 << 26)), int'($urandom_range(0, 1 << 26)));
        run_batch(60);
    endtask

    // result checker
    always @(posedge aclk) begin : check_drive
        drive_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drive.size() == 0) begin
                $error("drive word %h with nothing outstanding", m_tdata);
                n_errors++;
            end else begin
                want = pending_drive.pop_front();
                n_checked++;
                if (m_tdata !== want.drive) begin
                    $error("drive: expected %h, got %h", want.drive, m_tdata);
                    n_errors++;
                end
                if (m_tuser !== want.limited) begin
                    $error("limited: expected %b, got %b", want.limited, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (bursty && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= KIND_SAMPLE;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        bursty      = 1'b1;
        gain_p      = longint'($signed(PROP_GAIN_RST));
        gain_i      = 0;
        gain_d      = 0;
        period      = longint'(SAMPLE_TIME_RST);
        lim_lo      = longint'($signed(OUT_MIN_RST));
        lim_hi      = longint'($signed(OUT_MAX_RST));
        drive_acc   = 0;
        err_last    = 0;
        err_older   = 0;
        refresh_coefs();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_saturation_and_limits();
        test_tuning_sweeps();
        test_steady_tail();
        drain_results();

        $display("Sent %0d samples and %0d history clears across %0d register writes.",
                 n_samples, n_clears, n_writes);
        $display("Checked %0d drive words, %0d of them clamped.", n_checked, n_clamped);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
